// File: rtl/lrz_pkg.sv
package lrz_pkg;

  // Number formats
  localparam int FRAC_BITS = 24;
  localparam int CW        = 31;              // coefficient registers
  localparam int PW        = 32;              // point coordinates
  localparam int SPLIT     = 32;              // operand split for wide multiplies
  localparam int MW        = SPLIT + 2;       // multiplier operand width
  localparam int ACC_W     = 76;              // product accumulator
  localparam int DW        = ACC_W - FRAC_BITS; // temporaries and ALU
  localparam int IN_DW     = 6 * PW;
  localparam int OUT_DW    = 3 * PW;
  localparam int CFG_AW    = 2;
  localparam int PC_W      = 5;

  localparam logic [CW-1:0] STEP_SIZE_RST = 31'd167772;
  localparam logic [CW-1:0] SIGMA_RST     = 31'd167772160;
  localparam logic [CW-1:0] RHO_RST       = 31'd469762048;
  localparam logic [CW-1:0] BETA_RST      = 31'd44739243;

  localparam logic [CFG_AW-1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SIGMA     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RHO       = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_BETA      = 2'd3;

  localparam logic KIND_LOAD = 1'b0;

  localparam logic [PC_W-1:0] UA_STEP = 5'd0;
  localparam logic [PC_W-1:0] UA_LOAD = 5'd16;
  localparam logic [PC_W-1:0] UA_LAST = 5'd19;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ACC, SRC_TA, SRC_TB, SRC_TC, SRC_TD,
    SRC_H, SRC_SIG, SRC_RHO, SRC_BETA, SRC_X, SRC_Y, SRC_Z,
    SRC_SX, SRC_SY, SRC_SZ, SRC_OX, SRC_OY, SRC_OZ
  } src_t;

  typedef enum logic [1:0] {CHK_FULL, CHK_LO, CHK_HI} chunk_t;
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD_HI} acc_op_t;
  typedef enum logic [2:0] {DST_NONE, DST_TA, DST_TB, DST_TC, DST_TD} dst_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOAD_JMP, SEQ_DONE} seq_op_t;

  typedef struct packed {
    src_t            ma_src;
    chunk_t          ma_chk;
    src_t            mb_src;
    chunk_t          mb_chk;
    acc_op_t         acc_op;
    dst_t            wb_dst;
    src_t            wb_p;
    src_t            wb_q;
    logic            wb_sub;
    seq_op_t         seq;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic signed [DW-1:0] acc, ta, tb, tc, td;
    logic signed [DW-1:0] h, sig, rho, beta;
    logic signed [DW-1:0] x, y, z;
    logic signed [DW-1:0] sx, sy, sz, ox, oy, oz;
  } src_bus_t;

  typedef struct packed {
    logic [PW-1:0] v;
    logic          ovf;
  } sat_t;

  function automatic logic signed [DW-1:0] pick(input src_t s, input src_bus_t b);
    logic signed [DW-1:0] r;
    case (s)
      SRC_ZERO: r = '0;
      SRC_ACC:  r = b.acc;
      SRC_TA:   r = b.ta;
      SRC_TB:   r = b.tb;
      SRC_TC:   r = b.tc;
      SRC_TD:   r = b.td;
      SRC_H:    r = b.h;
      SRC_SIG:  r = b.sig;
      SRC_RHO:  r = b.rho;
      SRC_BETA: r = b.beta;
      SRC_X:    r = b.x;
      SRC_Y:    r = b.y;
      SRC_Z:    r = b.z;
      SRC_SX:   r = b.sx;
      SRC_SY:   r = b.sy;
      SRC_SZ:   r = b.sz;
      SRC_OX:   r = b.ox;
      SRC_OY:   r = b.oy;
      SRC_OZ:   r = b.oz;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // A wide operand v is hi * 2^SPLIT + lo, lo unsigned; narrow ones go in whole.
  function automatic logic signed [MW-1:0] chunk(input logic signed [DW-1:0] v,
                                                 input chunk_t c);
    logic signed [DW-1:0] hi;
    logic signed [MW-1:0] r;
    hi = v >>> SPLIT;
    case (c)
      CHK_FULL: r = v[MW-1:0];
      CHK_LO:   r = {{(MW-SPLIT){1'b0}}, v[SPLIT-1:0]};
      CHK_HI:   r = hi[MW-1:0];
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic sat_t sat32(input logic signed [DW-1:0] v);
    sat_t r;
    if ((&v[DW-1:PW-1]) || !(|v[DW-1:PW-1])) begin
      r.v   = v[PW-1:0];
      r.ovf = 1'b0;
    end else if (v[DW-1]) begin
      r.v   = {1'b1, {(PW-1){1'b0}}};
      r.ovf = 1'b1;
    end else begin
      r.v   = {1'b0, {(PW-1){1'b1}}};
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // Microprogram. A multiply issued in one word has its product in the next
  // word; an accumulator update is readable as SRC_ACC one word later.
  // Step:  TA = hs, x*y then q2, TB = y-x then new y, TC = rho-z, q1 then new z, TD = new x.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      PC_W'(0): begin
        w.ma_src = SRC_H;  w.mb_src = SRC_SIG;
        w.wb_dst = DST_TB; w.wb_p = SRC_Y; w.wb_q = SRC_X; w.wb_sub = 1'b1;
        w.seq = SEQ_LOAD_JMP; w.target = UA_LOAD;
      end
      PC_W'(1): begin
        w.acc_op = ACC_LOAD;
        w.wb_dst = DST_TC; w.wb_p = SRC_RHO; w.wb_q = SRC_Z; w.wb_sub = 1'b1;
      end
      PC_W'(2): begin
        w.ma_src = SRC_X;  w.mb_src = SRC_TC;
        w.wb_dst = DST_TA; w.wb_p = SRC_ZERO; w.wb_q = SRC_ACC;
      end
      PC_W'(3): begin
        w.ma_src = SRC_TA; w.ma_chk = CHK_LO; w.mb_src = SRC_TB;
        w.acc_op = ACC_LOAD;
      end
      PC_W'(4): begin
        w.ma_src = SRC_TA; w.ma_chk = CHK_HI; w.mb_src = SRC_TB;
        w.acc_op = ACC_LOAD;
        w.wb_dst = DST_TC; w.wb_p = SRC_ACC; w.wb_q = SRC_Y; w.wb_sub = 1'b1;
      end
      PC_W'(5): begin
        w.ma_src = SRC_H;  w.mb_src = SRC_TC; w.mb_chk = CHK_LO;
        w.acc_op = ACC_ADD_HI;
      end
      PC_W'(6): begin
        w.ma_src = SRC_H;  w.mb_src = SRC_TC; w.mb_chk = CHK_HI;
        w.acc_op = ACC_LOAD;
        w.wb_dst = DST_TD; w.wb_p = SRC_X; w.wb_q = SRC_ACC;
      end
      PC_W'(7): begin
        w.ma_src = SRC_X;  w.mb_src = SRC_Y;
        w.acc_op = ACC_ADD_HI;
      end
      PC_W'(8): begin
        w.ma_src = SRC_BETA; w.mb_src = SRC_Z;
        w.acc_op = ACC_LOAD;
        w.wb_dst = DST_TB; w.wb_p = SRC_Y; w.wb_q = SRC_ACC;
      end
      PC_W'(9): begin
        w.acc_op = ACC_LOAD;
        w.wb_dst = DST_TA; w.wb_p = SRC_ZERO; w.wb_q = SRC_ACC;
      end
      PC_W'(10): begin
        w.wb_dst = DST_TA; w.wb_p = SRC_TA; w.wb_q = SRC_ACC; w.wb_sub = 1'b1;
      end
      PC_W'(11): begin
        w.ma_src = SRC_H;  w.mb_src = SRC_TA; w.mb_chk = CHK_LO;
      end
      PC_W'(12): begin
        w.ma_src = SRC_H;  w.mb_src = SRC_TA; w.mb_chk = CHK_HI;
        w.acc_op = ACC_LOAD;
      end
      PC_W'(13): begin
        w.acc_op = ACC_ADD_HI;
      end
      PC_W'(14): begin
        w.wb_dst = DST_TC; w.wb_p = SRC_Z; w.wb_q = SRC_ACC;
      end
      PC_W'(15): begin
        w.seq = SEQ_DONE;
      end
      PC_W'(16): begin
        w.wb_dst = DST_TD; w.wb_p = SRC_SX; w.wb_q = SRC_OX;
      end
      PC_W'(17): begin
        w.wb_dst = DST_TB; w.wb_p = SRC_SY; w.wb_q = SRC_OY;
      end
      PC_W'(18): begin
        w.wb_dst = DST_TC; w.wb_p = SRC_SZ; w.wb_q = SRC_OZ;
      end
      PC_W'(19): begin
        w.seq = SEQ_DONE;
      end
      default: begin
        w.seq = SEQ_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/lorenz_euler_step.sv
// Forward-Euler integrator of the Lorenz system in signed Q8.24. A load beat
// (kind 0) sets the stored point to start plus offset; a step beat (kind 1)
// advances it one Euler step; each returns the new point with a saturation
// flag. A microcoded sequencer drives one shared 34x34 multiplier and an adder.
// A step beat runs through the whole program, whose length is set by the ten
// multiplier passes it needs (wide products go through the multiplier in two
// halves); a load beat jumps to a short tail of it. A new beat is taken only
// once the last one has committed. A result waiting on the output holds the
// final program word, and so the next beat.
// The user must write coefficient registers only while the block is idle; the block itself does not enforce it.
module lorenz_euler_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x, start_y, start_z, offset_x, offset_y, offset_z
  input  logic [lrz_pkg::IN_DW-1:0]     in_tdata,
  // kind
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // point_x, point_y, point_z
  output logic [lrz_pkg::OUT_DW-1:0]    out_tdata,
  // overflow
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [lrz_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [lrz_pkg::CW-1:0]        cfg_wdata
);

  localparam int PW = lrz_pkg::PW;
  localparam int DW = lrz_pkg::DW;
  localparam int CW = lrz_pkg::CW;
  localparam int MW = lrz_pkg::MW;
  localparam int ACC_W = lrz_pkg::ACC_W;
  localparam int SPLIT = lrz_pkg::SPLIT;

  logic                          busy_r;
  logic [lrz_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic                          kind_r;
  logic signed [PW-1:0]          sx_r, sy_r, sz_r, ox_r, oy_r, oz_r;
  logic [CW-1:0]                 h_r, sig_r, rho_r, beta_r;
  logic signed [PW-1:0]          px_r, py_r, pz_r;
  logic signed [DW-1:0]          ta_r, tb_r, tc_r, td_r;
  logic signed [2*MW-1:0]        prod_r;
  logic signed [ACC_W-1:0]       acc_r, acc_shr;
  logic                          out_valid_r;
  logic [lrz_pkg::OUT_DW-1:0]    out_data_r;
  logic                          out_ovf_r;

  lrz_pkg::uword_t               uw;
  lrz_pkg::src_bus_t             bus;
  logic signed [MW-1:0]          ma, mb;
  logic signed [DW-1:0]          wb_p, wb_q, wb_res;
  lrz_pkg::sat_t                 sat_x, sat_y, sat_z;
  logic                          accept, commit;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign uw        = lrz_pkg::ucode(pc_r);
  assign acc_shr   = acc_r >>> lrz_pkg::FRAC_BITS;

  always_comb begin
    bus.acc  = acc_shr[DW-1:0];
    bus.ta   = ta_r;
    bus.tb   = tb_r;
    bus.tc   = tc_r;
    bus.td   = td_r;
    bus.h    = {{(DW-CW){1'b0}}, h_r};
    bus.sig  = {{(DW-CW){1'b0}}, sig_r};
    bus.rho  = {{(DW-CW){1'b0}}, rho_r};
    bus.beta = {{(DW-CW){1'b0}}, beta_r};
    bus.x    = {{(DW-PW){px_r[PW-1]}}, px_r};
    bus.y    = {{(DW-PW){py_r[PW-1]}}, py_r};
    bus.z    = {{(DW-PW){pz_r[PW-1]}}, pz_r};
    bus.sx   = {{(DW-PW){sx_r[PW-1]}}, sx_r};
    bus.sy   = {{(DW-PW){sy_r[PW-1]}}, sy_r};
    bus.sz   = {{(DW-PW){sz_r[PW-1]}}, sz_r};
    bus.ox   = {{(DW-PW){ox_r[PW-1]}}, ox_r};
    bus.oy   = {{(DW-PW){oy_r[PW-1]}}, oy_r};
    bus.oz   = {{(DW-PW){oz_r[PW-1]}}, oz_r};
  end

  assign ma     = lrz_pkg::chunk(lrz_pkg::pick(uw.ma_src, bus), uw.ma_chk);
  assign mb     = lrz_pkg::chunk(lrz_pkg::pick(uw.mb_src, bus), uw.mb_chk);
  assign wb_p   = lrz_pkg::pick(uw.wb_p, bus);
  assign wb_q   = lrz_pkg::pick(uw.wb_q, bus);
  assign wb_res = uw.wb_sub ? (wb_p - wb_q) : (wb_p + wb_q);

  assign sat_x = lrz_pkg::sat32(td_r);
  assign sat_y = lrz_pkg::sat32(tb_r);
  assign sat_z = lrz_pkg::sat32(tc_r);

  // The final word waits until the output register is free.
  assign commit = busy_r && (uw.seq == lrz_pkg::SEQ_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    pc_nxt = pc_r + 1'b1;
    case (uw.seq)
      lrz_pkg::SEQ_NEXT:     pc_nxt = pc_r + 1'b1;
      lrz_pkg::SEQ_LOAD_JMP: pc_nxt = (kind_r == lrz_pkg::KIND_LOAD) ? uw.target : pc_r + 1'b1;
      lrz_pkg::SEQ_DONE:     pc_nxt = pc_r;
      default:               pc_nxt = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= lrz_pkg::UA_STEP;
      out_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      h_r         <= lrz_pkg::STEP_SIZE_RST;
      sig_r       <= lrz_pkg::SIGMA_RST;
      rho_r       <= lrz_pkg::RHO_RST;
      beta_r      <= lrz_pkg::BETA_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          lrz_pkg::CFG_STEP_SIZE: h_r    <= cfg_wdata;
          lrz_pkg::CFG_SIGMA:     sig_r  <= cfg_wdata;
          lrz_pkg::CFG_RHO:       rho_r  <= cfg_wdata;
          lrz_pkg::CFG_BETA:      beta_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        busy_r      <= 1'b0;
        pc_r        <= lrz_pkg::UA_STEP;
        out_valid_r <= 1'b1;
        px_r        <= sat_x.v;
        py_r        <= sat_y.v;
        pz_r        <= sat_z.v;
      end else begin
        if (out_valid_r && out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (accept) begin
          busy_r <= 1'b1;
          pc_r   <= lrz_pkg::UA_STEP;
        end else if (busy_r) begin
          pc_r <= pc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser[0];
      sx_r   <= in_tdata[0*PW +: PW];
      sy_r   <= in_tdata[1*PW +: PW];
      sz_r   <= in_tdata[2*PW +: PW];
      ox_r   <= in_tdata[3*PW +: PW];
      oy_r   <= in_tdata[4*PW +: PW];
      oz_r   <= in_tdata[5*PW +: PW];
    end
    prod_r <= (2*MW)'(ma) * (2*MW)'(mb);
    case (uw.acc_op)
      lrz_pkg::ACC_LOAD:   acc_r <= {{(ACC_W-2*MW){prod_r[2*MW-1]}}, prod_r};
      lrz_pkg::ACC_ADD_HI: acc_r <= acc_r + {prod_r[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}};
      default: ;
    endcase
    if (busy_r) begin
      case (uw.wb_dst)
        lrz_pkg::DST_TA: ta_r <= wb_res;
        lrz_pkg::DST_TB: tb_r <= wb_res;
        lrz_pkg::DST_TC: tc_r <= wb_res;
        lrz_pkg::DST_TD: td_r <= wb_res;
        default: ;
      endcase
    end
    if (commit) begin
      out_data_r <= {sat_z.v, sat_y.v, sat_x.v};
      out_ovf_r  <= sat_x.ovf | sat_y.ovf | sat_z.ovf;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ovf_r;

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && (pc_r == lrz_pkg::UA_STEP))
    else $error("sequencer did not start after an input beat");

  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(commit))
    else $error("result raised without a final program word");

  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= lrz_pkg::UA_LAST))
    else $error("program counter left the microprogram");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !busy_r && out_tvalid)
    else $error("commit did not release the sequencer");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic KIND_STEP = ~lrz_pkg::KIND_LOAD;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0100_0000;
  localparam logic [30:0] CMAX = 31'h7FFF_FFFF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        ovf;
  } point_t;

  typedef struct {
    logic                      kind;
    logic [lrz_pkg::IN_DW-1:0] data;
    bit                        typed;
    point_t                    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [lrz_pkg::IN_DW-1:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lrz_pkg::OUT_DW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we;
  logic [lrz_pkg::CFG_AW-1:0] cfg_addr;
  logic [lrz_pkg::CW-1:0] cfg_wdata;

  // Model of the integrator: coefficients and the stored point.
  longint coef_h, coef_sigma, coef_rho, coef_beta;
  longint cur_x, cur_y, cur_z;

  point_t point_q[$];
  row_t plan[$];
  int errors = 0;
  int cycles = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  lorenz_euler_step dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_miss(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // floor(a*b / 2^FRAC_BITS) of the exact product, clamped to 64 bits.
  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] wa, wb, p;
    wa = 128'(a);
    wb = 128'(b);
    p = (wa * wb) >>> lrz_pkg::FRAC_BITS;
    if ((&p[127:63]) || !(|p[127:63])) return p[63:0];
    return p[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic longint sat_sum(input longint a, input longint b, input bit sub);
    logic signed [64:0] wa, wb, s;
    wa = 65'(a);
    wb = 65'(b);
    s = sub ? wa - wb : wa + wb;
    if (s[64] != s[63])
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lane(input logic [lrz_pkg::IN_DW-1:0] d, input int i);
    return longint'($signed(d[i*32 +: 32]));
  endfunction

  // Advances the stored point by one beat and returns the point it reports.
  function automatic point_t lorenz_next(input logic kind,
                                         input logic [lrz_pkg::IN_DW-1:0] d);
    longint nx, ny, nz, hs, q, cx, cy, cz;
    point_t r;
    if (kind == lrz_pkg::KIND_LOAD) begin
      nx = lane(d, 0) + lane(d, 3);
      ny = lane(d, 1) + lane(d, 4);
      nz = lane(d, 2) + lane(d, 5);
    end else begin
      // All three coordinates come from the old point.
      hs = fx_mul(coef_h, coef_sigma);
      nx = sat_sum(cur_x, fx_mul(hs, cur_y - cur_x), 1'b0);
      q = sat_sum(fx_mul(cur_x, coef_rho - cur_z), cur_y, 1'b1);
      ny = sat_sum(cur_y, fx_mul(coef_h, q), 1'b0);
      q = sat_sum(fx_mul(cur_x, cur_y), fx_mul(coef_beta, cur_z), 1'b1);
      nz = sat_sum(cur_z, fx_mul(coef_h, q), 1'b0);
    end
    cx = clamp32(nx);
    cy = clamp32(ny);
    cz = clamp32(nz);
    r.ovf = (cx != nx) || (cy != ny) || (cz != nz);
    cur_x = cx;
    cur_y = cy;
    cur_z = cz;
    r.px = cx[31:0];
    r.py = cy[31:0];
    r.pz = cz[31:0];
    return r;
  endfunction

  function automatic logic [lrz_pkg::IN_DW-1:0] pack_in(input logic [31:0] sx, sy, sz,
                                                        input logic [31:0] ox, oy, oz);
    return {oz, oy, ox, sz, sy, sx};
  endfunction

  function automatic logic [lrz_pkg::IN_DW-1:0] rand_bits();
    logic [lrz_pkg::IN_DW-1:0] d;
    for (int i = 0; i < 6; i++) d[i*32 +: 32] = $urandom();
    return d;
  endfunction

  // Mostly a start near the attractor with a small nudge; sometimes anything.
  function automatic logic [lrz_pkg::IN_DW-1:0] start_point();
    logic [lrz_pkg::IN_DW-1:0] d;
    if ($urandom_range(9) < 3) return rand_bits();
    for (int i = 0; i < 3; i++)
      d[i*32 +: 32] = $urandom_range(0, 32'd1342177280) - 32'd671088640;
    for (int i = 3; i < 6; i++)
      d[i*32 +: 32] = $urandom_range(0, 131072) - 32'd65536;
    return d;
  endfunction

  function automatic void add_row(input logic kind, input logic [lrz_pkg::IN_DW-1:0] d,
                                  input bit typed, input point_t want);
    row_t r;
    r.kind = kind;
    r.data = d;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_beat(input logic kind, input logic [lrz_pkg::IN_DW-1:0] d,
                           input bit typed, input point_t want);
    point_t p;
    while (!steady && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = lorenz_next(kind, d);
    point_q.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (point_q.size() != 0);
  endtask

  task automatic cfg_put(input logic [lrz_pkg::CFG_AW-1:0] idx,
                         input logic [lrz_pkg::CW-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic write_coefs(input logic [lrz_pkg::CW-1:0] h, s, r, b);
    cfg_put(lrz_pkg::CFG_STEP_SIZE, h);
    cfg_put(lrz_pkg::CFG_SIGMA, s);
    cfg_put(lrz_pkg::CFG_RHO, r);
    cfg_put(lrz_pkg::CFG_BETA, b);
    cfg_we <= 1'b0;
    coef_h = longint'(h);
    coef_sigma = longint'(s);
    coef_rho = longint'(r);
    coef_beta = longint'(b);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        push_beat(1'($urandom_range(1)), rand_bits(), 1'b0, '0);
        sent++;
      end else begin
        push_beat(lrz_pkg::KIND_LOAD, start_point(), 1'b0, '0);
        run_len = $urandom_range(3, 30);
        repeat (run_len) push_beat(KIND_STEP, rand_bits(), 1'b0, '0);
        sent += run_len + 1;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser[0]};
      if (point_q.size() == 0) begin
        report_miss("result beat with nothing pending");
      end else begin
        want = point_q.pop_front();
        if (got.px !== want.px)
          report_miss($sformatf("point_x got %h want %h", got.px, want.px));
        if (got.py !== want.py)
          report_miss($sformatf("point_y got %h want %h", got.py, want.py));
        if (got.pz !== want.pz)
          report_miss($sformatf("point_z got %h want %h", got.pz, want.pz));
        if (got.ovf !== want.ovf)
          report_miss($sformatf("overflow got %b want %b", got.ovf, want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    coef_h = longint'(lrz_pkg::STEP_SIZE_RST);
    coef_sigma = longint'(lrz_pkg::SIGMA_RST);
    coef_rho = longint'(lrz_pkg::RHO_RST);
    coef_beta = longint'(lrz_pkg::BETA_RST);
    cur_x = 0;
    cur_y = 0;
    cur_z = 0;

    // A step straight out of reset integrates from the origin and stays there.
    add_row(KIND_STEP, '1, 1'b1, point_t'{32'h0, 32'h0, 32'h0, 1'b0});
    add_row(lrz_pkg::KIND_LOAD, '0, 1'b1, point_t'{32'h0, 32'h0, 32'h0, 1'b0});
    add_row(lrz_pkg::KIND_LOAD, pack_in(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1'b1,
            point_t'{MAXV, MAXV, MAXV, 1'b1});
    add_row(KIND_STEP, rand_bits(), 1'b0, '0);
    add_row(lrz_pkg::KIND_LOAD, pack_in(MINV, MINV, MINV, MINV, MINV, MINV), 1'b1,
            point_t'{MINV, MINV, MINV, 1'b1});
    add_row(KIND_STEP, '0, 1'b0, '0);
    add_row(lrz_pkg::KIND_LOAD, pack_in(MAXV, MINV, 32'h0, 32'h0, 32'h0, 32'h0), 1'b1,
            point_t'{MAXV, MINV, 32'h0, 1'b0});
    add_row(KIND_STEP, '1, 1'b0, '0);
    add_row(lrz_pkg::KIND_LOAD, pack_in(MINV, MAXV, MINV, MAXV, MINV, MAXV), 1'b1,
            point_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
    add_row(KIND_STEP, rand_bits(), 1'b0, '0);
    // Only x leaves the range here, which alone must raise the flag.
    add_row(lrz_pkg::KIND_LOAD,
            pack_in(MAXV, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1),
            1'b1, point_t'{MAXV, 32'h0, 32'h0, 1'b1});
    add_row(KIND_STEP, rand_bits(), 1'b0, '0);
    add_row(lrz_pkg::KIND_LOAD, pack_in(ONE, ONE, ONE, 32'h0, 32'h0, 32'h0), 1'b1,
            point_t'{ONE, ONE, ONE, 1'b0});
    repeat (5) add_row(KIND_STEP, rand_bits(), 1'b0, '0);
    add_row(lrz_pkg::KIND_LOAD, pack_in(32'hF800_0000, 32'hF800_0000, 32'h1B00_0000,
                                        32'h1, 32'hFFFF_FFFF, 32'h0),
            1'b1, point_t'{32'hF800_0001, 32'hF7FF_FFFF, 32'h1B00_0000, 1'b0});
    repeat (5) add_row(KIND_STEP, rand_bits(), 1'b0, '0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) push_beat(plan[i].kind, plan[i].data, plan[i].typed, plan[i].want);
    run_phase(280);

    settle();
    write_coefs(CMAX, CMAX, CMAX, CMAX);
    run_phase(100);

    settle();
    write_coefs('0, '0, '0, '0);
    run_phase(100);

    settle();
    write_coefs(31'h1000, CMAX, '0, CMAX);
    run_phase(150);

    repeat (4) begin
      settle();
      write_coefs(lrz_pkg::CW'($urandom_range(0, CMAX)),
                  lrz_pkg::CW'($urandom_range(0, CMAX)),
                  lrz_pkg::CW'($urandom_range(0, CMAX)),
                  lrz_pkg::CW'($urandom_range(0, CMAX)));
      run_phase(175);
    end

    settle();
    write_coefs(lrz_pkg::STEP_SIZE_RST, lrz_pkg::SIGMA_RST, lrz_pkg::RHO_RST,
                lrz_pkg::BETA_RST);
    steady = 1'b1;
    run_phase(120);
    steady = 1'b0;
    // The output is held off while beats keep coming, so the input backs up.
    hold_req = 1'b1;
    run_phase(60);
    settle();
    run_phase(100);

    settle();
    repeat (40) @(negedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
